// File: sv/sem_pkg.sv
package sem_pkg;

   localparam int SLOTS       = 32;
   localparam int QUEUE_DEPTH = 16;
   localparam int TASK_BITS   = 6;

   localparam int SLOT_BITS  = $clog2(SLOTS);
   localparam int QPTR_BITS  = $clog2(QUEUE_DEPTH);
   localparam int STORE_BITS = SLOT_BITS + QPTR_BITS;

   // Field widths of the stream beats.
   localparam int OP_W     = 2;
   localparam int KEY_W    = 64;
   localparam int INIT_W   = 15;
   localparam int SLOTIN_W = 5;
   localparam int TASKIN_W = 6;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 16;
   localparam int REQ_W    = 96;
   localparam int RSP_W    = 32;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_OPEN   = 2'd0;
   localparam logic [OP_W-1:0] OP_WAIT   = 2'd1;
   localparam logic [OP_W-1:0] OP_POST   = 2'd2;
   localparam logic [OP_W-1:0] OP_UNLINK = 2'd3;

   // Status codes.
   localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_CREATED  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NOFREE   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
   localparam logic [STATUS_W-1:0] ST_QFULL    = 3'd4;

   // Per-slot record held in the slot memory.
   typedef struct packed {
      logic [COUNT_W-1:0]   count;
      logic [QPTR_BITS-1:0] head;
      logic [QPTR_BITS-1:0] tail;
   } slot_rec_type;

   localparam int REC_W = $bits(slot_rec_type);

endpackage

// File: sv/sem_ram.sv
module sem_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// File: sv/semaphore_table_with_wait_queues_top.sv
// Table of counting semaphores with per-slot FIFO wait queues. Each request
// beat (open, wait, post or unlink) gives exactly one response beat. When a
// request is accepted, the slot record and the waiter ring are read from their
// synchronous memories; while busy, the key match over the valid-bit and key
// registers settles and the record is modified and written back; the result is
// then held in an output register. No new beat is taken while a request is in
// flight or a held response is not taken. No clearing pass is needed after reset.
module semaphore_table_with_wait_queues_top (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // op[1:0], name_key[65:2], init_count[80:66], slot[85:81], task_id[91:86]
   input  logic [sem_pkg::REQ_W-1:0] req_tdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // status[2:0], slot_out[7:3], blocked[8], woke[9], woken_task[15:10],
   // count_after[31:16]
   output logic [sem_pkg::RSP_W-1:0] rsp_tdata
);
   import sem_pkg::*;

   // Request fields.
   logic [OP_W-1:0]      op;
   logic [KEY_W-1:0]     name_key;
   logic [INIT_W-1:0]    init_count;
   logic [SLOTIN_W-1:0]  slot;
   logic [TASKIN_W-1:0]  task_id;

   logic                 busy_ff, busy_in;
   logic [OP_W-1:0]      op_ff;
   logic [KEY_W-1:0]     key_ff;
   logic [INIT_W-1:0]    init_ff;
   logic [SLOTIN_W-1:0]  slot_ff;
   logic [TASK_BITS-1:0] task_ff;

   logic [SLOTS-1:0]     used_ff, used_in;
   logic [KEY_W-1:0]     keys_ff [SLOTS];

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]     rsp_data_ff, rsp_data_in;

   logic                 accept;

   assign op         = req_tdata[1:0];
   assign name_key   = req_tdata[65:2];
   assign init_count = req_tdata[80:66];
   assign slot       = req_tdata[85:81];
   assign task_id    = req_tdata[91:86];

   // One request in flight; a new beat enters once the result register frees.
   assign req_tready = !busy_ff && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   // Key match and free-slot search over the registered table.
   logic [SLOTS-1:0]     match_vec;
   logic                 match_any, free_any;
   logic [SLOT_BITS-1:0] match_idx, free_idx;

   always_comb begin
      match_any = 1'b0;
      match_idx = '0;
      free_any  = 1'b0;
      free_idx  = '0;
      for (int i = 0; i < SLOTS; i++) begin
         match_vec[i] = used_ff[i] && (keys_ff[i] == key_ff);
      end
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (match_vec[i]) begin
            match_any = 1'b1;
            match_idx = SLOT_BITS'(i);
         end
         if (!used_ff[i]) begin
            free_any = 1'b1;
            free_idx = SLOT_BITS'(i);
         end
      end
   end

   // Memories: slot records and waiter ring.
   slot_rec_type          rec_rd, rec_wr;
   logic                  rec_we;
   logic [SLOT_BITS-1:0]  rec_waddr;
   logic [SLOT_BITS-1:0]  rec_raddr;
   logic [TASK_BITS-1:0]  wq_rd, wq_wr;
   logic                  wq_we;
   logic [STORE_BITS-1:0] wq_waddr, wq_raddr;

   // Read address for the ring follows the head; the slot record is not yet
   // available when the ring is read, so the waiter read uses the head from a side copy.
   logic [QPTR_BITS-1:0]  head_ff [SLOTS];

   assign rec_raddr = slot[SLOT_BITS-1:0];
   assign wq_raddr  = {slot[SLOT_BITS-1:0], head_ff[slot[SLOT_BITS-1:0]]};

   sem_ram #(.WIDTH(REC_W), .DEPTH(SLOTS)) u_rec_ram (
      .clock   (clock),
      .wr_en   (rec_we),
      .wr_addr (rec_waddr),
      .wr_data (rec_wr),
      .rd_addr (rec_raddr),
      .rd_data (rec_rd)
   );

   sem_ram #(.WIDTH(TASK_BITS), .DEPTH(SLOTS * QUEUE_DEPTH)) u_wait_ram (
      .clock   (clock),
      .wr_en   (wq_we),
      .wr_addr (wq_waddr),
      .wr_data (wq_wr),
      .rd_addr (wq_raddr),
      .rd_data (wq_rd)
   );

   // Count and queue pointers of a matched slot come from the register copy.
   logic [COUNT_W-1:0] cnt_copy_ff [SLOTS];
   logic [QPTR_BITS-1:0] tail_copy_ff [SLOTS];

   function automatic logic [COUNT_W-1:0] count_of(input logic [SLOT_BITS-1:0] i);
      count_of = cnt_copy_ff[i];
   endfunction

   function automatic slot_rec_type count_rec(input logic [SLOT_BITS-1:0] i);
      slot_rec_type r;
      r.count   = cnt_copy_ff[i];
      r.head    = head_ff[i];
      r.tail    = tail_copy_ff[i];
      count_rec = r;
   endfunction

   // While busy: modify the record and form the result.
   logic [STATUS_W-1:0]  st;
   logic [SLOT_BITS-1:0] sout, s_idx;
   logic                 blk, wk;
   logic [TASK_BITS-1:0] wtask;
   logic signed [COUNT_W-1:0] cnt, cur;
   logic [QPTR_BITS-1:0] nt, nh;
   logic                 slot_ok;

   assign s_idx   = slot_ff[SLOT_BITS-1:0];
   assign slot_ok = (32'(slot_ff) < SLOTS) && used_ff[s_idx];

   always_comb begin
      st        = ST_OK;
      sout      = '0;
      blk       = 1'b0;
      wk        = 1'b0;
      wtask     = '0;
      cnt       = '0;
      cur       = signed'(rec_rd.count);
      nt        = rec_rd.tail + 1'b1;
      nh        = rec_rd.head + 1'b1;
      rec_we    = 1'b0;
      rec_waddr = s_idx;
      rec_wr    = rec_rd;
      wq_we     = 1'b0;
      wq_waddr  = {s_idx, rec_rd.tail};
      wq_wr     = task_ff;
      used_in   = used_ff;
      if (busy_ff) begin
         unique case (op_ff)
            OP_OPEN: begin
               if (match_any) begin
                  sout = match_idx;
                  cnt  = signed'(count_of(match_idx));
               end else if (free_any) begin
                  st                = ST_CREATED;
                  sout              = free_idx;
                  cnt               = COUNT_W'(init_ff);
                  rec_we            = 1'b1;
                  rec_waddr         = free_idx;
                  rec_wr.count      = COUNT_W'(init_ff);
                  rec_wr.head       = '0;
                  rec_wr.tail       = '0;
                  used_in[free_idx] = 1'b1;
               end else begin
                  st = ST_NOFREE;
               end
            end
            OP_UNLINK: begin
               if (match_any) begin
                  sout               = match_idx;
                  rec_we             = 1'b1;
                  rec_waddr          = match_idx;
                  rec_wr             = count_rec(match_idx);
                  rec_wr.count       = '0;
                  used_in[match_idx] = 1'b0;
               end else begin
                  st = ST_NOTFOUND;
               end
            end
            OP_WAIT: begin
               if (!slot_ok) begin
                  st = ST_NOTFOUND;
               end else begin
                  cnt          = (cur == {1'b1, {(COUNT_W-1){1'b0}}}) ? cur : cur - 1'b1;
                  rec_we       = 1'b1;
                  rec_wr.count = cnt;
                  if (cnt[COUNT_W-1]) begin
                     if (nt == rec_rd.head) begin
                        st = ST_QFULL;
                     end else begin
                        wq_we       = 1'b1;
                        rec_wr.tail = nt;
                        blk         = 1'b1;
                     end
                  end
               end
            end
            OP_POST: begin
               if (!slot_ok) begin
                  st = ST_NOTFOUND;
               end else begin
                  cnt          = (cur == {1'b0, {(COUNT_W-1){1'b1}}}) ? cur : cur + 1'b1;
                  rec_we       = 1'b1;
                  rec_wr.count = cnt;
                  if ((cnt[COUNT_W-1] || cnt == '0) && rec_rd.head != rec_rd.tail) begin
                     rec_wr.head = nh;
                     wk          = 1'b1;
                     wtask       = wq_rd;
                  end
               end
            end
            default: ;
         endcase
      end
      rsp_data_in = RSP_W'({cnt, TASKIN_W'(wtask), wk, blk, SLOTIN_W'(sout), st});
   end

   // Result register.
   always_comb begin
      busy_in      = busy_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         busy_in = 1'b1;
      end else if (busy_ff) begin
         busy_in      = 1'b0;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         used_ff      <= '0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         used_ff      <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            head_ff[i]      <= '0;
            tail_copy_ff[i] <= '0;
            cnt_copy_ff[i]  <= '0;
            keys_ff[i]      <= '0;
         end
      end else if (busy_ff && rec_we) begin
         head_ff[rec_waddr]      <= rec_wr.head;
         tail_copy_ff[rec_waddr] <= rec_wr.tail;
         cnt_copy_ff[rec_waddr]  <= rec_wr.count;
         if (op_ff == OP_OPEN) begin
            keys_ff[rec_waddr] <= key_ff;
         end else if (op_ff == OP_UNLINK) begin
            keys_ff[rec_waddr] <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff       <= op;
         key_ff      <= name_key;
         init_ff     <= init_count;
         slot_ff     <= slot;
         task_ff     <= task_id[TASK_BITS-1:0];
      end
      if (busy_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: sv/sem_checker.sv
module sem_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_tvalid,
   input logic                      req_tready,
   input logic [sem_pkg::REQ_W-1:0] req_tdata,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [sem_pkg::RSP_W-1:0] rsp_tdata
);
   import sem_pkg::*;

   // A response beat waiting for space holds steady.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // Each accepted request gives a response once it has passed the busy and result registers.
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> ##1 rsp_tvalid)
      else $error("response missing after request");

   // No request is taken in the cycle right after another one.
   a_spacing: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("back-to-back accept");

   // Blocked and woke never appear together.
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[8] && rsp_tdata[9]))
      else $error("blocked and woke both set");

endmodule

bind semaphore_table_with_wait_queues_top sem_checker u_sem_checker (.*);
